// ===== rtl/csplev_pkg.sv =====
// Shared types, sizes and codes for the cubic spline evaluator.
// Self-contained; the MAC, top level and checker refer to it by scoped names.
`default_nettype none

package csplev_pkg;

	// table sizes
	localparam int MAX_SEGMENTS = 16;
	localparam int FRAC_BITS    = 16;
	localparam int NBREAK       = MAX_SEGMENTS + 1;
	localparam int NCOEFF       = 4 * MAX_SEGMENTS;

	// widths
	localparam int DATA_W   = 32;
	localparam int CNT_W    = 5;
	localparam int SEG_W    = $clog2(MAX_SEGMENTS);
	localparam int BRK_AW   = $clog2(NBREAK);
	localparam int CF_AW    = $clog2(NCOEFF);
	localparam int PROD_W   = 2 * DATA_W;
	localparam int RND_W    = PROD_W + 1;
	localparam int SUM_W    = RND_W + 1;

	// input item codes
	typedef enum logic [1:0] {
		ACT_EVAL     = 2'd0,
		ACT_WR_BREAK = 2'd1,
		ACT_WR_COEFF = 2'd2
	} action_t;

	// evaluation sequencer
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RD_UP,
		ST_CMP_UP,
		ST_RD_LO,
		ST_DELTA,
		ST_MUL,
		ST_ADD,
		ST_DONE
	} state_t;

endpackage

`default_nettype wire

// ===== rtl/csplev_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies; used for the break and coefficient tables.
`default_nettype none

module csplev_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read port; read data holds when not enabled
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== rtl/csplev_mac.sv =====
// Horner step unit: registered 32x32 multiply, then round, add and saturate.
// Depends on csplev_pkg for widths and the fraction size.
`default_nettype none

module csplev_mac (
	input  wire logic                           clk,
	input  wire logic                           mul_en,
	input  wire logic [csplev_pkg::DATA_W-1:0]  mul_a,
	input  wire logic [csplev_pkg::DATA_W-1:0]  mul_b,
	input  wire logic [csplev_pkg::DATA_W-1:0]  addend,
	output logic      [csplev_pkg::DATA_W-1:0]  sum,
	output logic                                ovf
);

	localparam int DW = csplev_pkg::DATA_W;
	localparam int FB = csplev_pkg::FRAC_BITS;
	localparam int RW = csplev_pkg::RND_W;
	localparam int SW = csplev_pkg::SUM_W;

	logic signed [csplev_pkg::PROD_W-1:0] prod_q;
	logic signed [RW-1:0]                 biased;
	logic signed [RW-1:0]                 rounded;
	logic signed [SW-1:0]                 total;
	logic [SW-DW:0]                       top_bits;

	// product register
	always_ff @(posedge clk) begin
		if (mul_en) begin
			prod_q <= $signed(mul_a) * $signed(mul_b);
		end
	end

	// round half up: add half an LSB, then floor by arithmetic shift
	always_comb begin
		biased   = RW'(prod_q) + (RW'(1) <<< (FB - 1));
		rounded  = biased >>> FB;
		total    = SW'(rounded) + SW'($signed(addend));
		top_bits = total[SW-1:DW-1];
		ovf      = !((&top_bits) || !(|top_bits));
		if (!ovf) begin
			sum = total[DW-1:0];
		end else if (total[SW-1]) begin
			sum = {1'b1, {(DW-1){1'b0}}};
		end else begin
			sum = {1'b0, {(DW-1){1'b1}}};
		end
	end

endmodule

`default_nettype wire

// ===== rtl/cubic_spline_evaluator_core.sv =====
// Piecewise cubic spline evaluator: top level with sequencer and tables.
// Depends on csplev_pkg, csplev_ram and csplev_mac.
//
// Usage:
//   Input channel (in_valid/in_stall) carries one word: action, index, value.
//   A breakpoint or coefficient write commits in the accepting cycle and
//   yields nothing; action 3 is dropped. An evaluate word yields one result
//   word (result, segment, saturated) on the output channel (out_valid/out_stall).
//   The segment_count register is written through cfg_valid/cfg_ready/cfg_data;
//   cfg_ready is always high, and writes are meant for idle periods only.
// Operation:
//   An evaluation runs from acceptance to the result register as follows:
//   the break search reads one upper break at a time through the registered
//   RAM port and compares it, then the lower break is read and three Horner
//   steps of multiply and add follow. in_stall is high while an evaluation
//   runs. The output register holds a finished result while out_stall is high;
//   the block still takes new words, and a following result waits in the
//   sequencer until the register frees.
// Reset: arst_n clears the sequencer, the output valid and sets segment_count
//   to 1. Table contents are undefined until written.
`default_nettype none

module cubic_spline_evaluator_core (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	// input channel
	input  wire logic                              in_valid,
	output logic                                   in_stall,
	input  wire logic [1:0]                        action,
	input  wire logic [5:0]                        index,
	input  wire logic [csplev_pkg::DATA_W-1:0]     value,
	// output channel
	output logic                                   out_valid,
	input  wire logic                              out_stall,
	output logic      [csplev_pkg::DATA_W-1:0]     result,
	output logic      [csplev_pkg::SEG_W-1:0]      segment,
	output logic                                   saturated,
	// configuration channel
	input  wire logic                              cfg_valid,
	output logic                                   cfg_ready,
	input  wire logic [csplev_pkg::CNT_W-1:0]      cfg_data
);

	localparam int DW  = csplev_pkg::DATA_W;
	localparam int SGW = csplev_pkg::SEG_W;
	localparam int BAW = csplev_pkg::BRK_AW;
	localparam int CAW = csplev_pkg::CF_AW;
	localparam int CW  = csplev_pkg::CNT_W;

	csplev_pkg::state_t state_q, state_nxt;

	logic [CW-1:0]  seg_count_q;
	logic [DW-1:0]  x_q;
	logic [SGW-1:0] n_last_q;
	logic [SGW-1:0] i_q;
	logic [1:0]     k_q;
	logic [DW-1:0]  d_q;
	logic [DW-1:0]  acc_q;
	logic           sat_q;

	logic           out_valid_q;
	logic [DW-1:0]  result_q;
	logic [SGW-1:0] segment_q;
	logic           saturated_q;

	logic           in_acc;
	logic           eval_acc;
	logic           out_free;
	logic           found;
	logic [CW-1:0]  n_eff;

	logic           brk_we, brk_re;
	logic [BAW-1:0] brk_raddr;
	logic [DW-1:0]  brk_rdata;
	logic           cf_we, cf_re;
	logic [CAW-1:0] cf_raddr;
	logic [DW-1:0]  cf_rdata;

	logic           mul_en;
	logic [DW-1:0]  mac_sum;
	logic           mac_ovf;

	logic [DW:0]    diff;
	logic           d_ovf;
	logic [DW-1:0]  d_clamped;

	// handshakes
	assign in_stall  = (state_q != csplev_pkg::ST_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign eval_acc  = in_acc && (action == csplev_pkg::ACT_EVAL);
	assign out_free  = !out_valid_q || !out_stall;
	assign cfg_ready = 1'b1;

	assign out_valid = out_valid_q;
	assign result    = result_q;
	assign segment   = segment_q;
	assign saturated = saturated_q;

	// table writes commit in the accepting cycle
	assign brk_we = in_acc && (action == csplev_pkg::ACT_WR_BREAK)
		&& (int'(index) < csplev_pkg::NBREAK);
	assign cf_we  = in_acc && (action == csplev_pkg::ACT_WR_COEFF)
		&& (int'(index) < csplev_pkg::NCOEFF);

	// effective interval count: zero acts as one, large values as the maximum
	always_comb begin
		if (seg_count_q == '0) begin
			n_eff = CW'(1);
		end else if (int'(seg_count_q) > csplev_pkg::MAX_SEGMENTS) begin
			n_eff = CW'(csplev_pkg::MAX_SEGMENTS);
		end else begin
			n_eff = seg_count_q;
		end
	end

	// break search stop condition
	assign found = ($signed(x_q) <= $signed(brk_rdata)) || (i_q == n_last_q);

	// delta from the lower break, saturated to 32 bits
	always_comb begin
		diff  = {x_q[DW-1], x_q} - {brk_rdata[DW-1], brk_rdata};
		d_ovf = diff[DW] != diff[DW-1];
		if (!d_ovf) begin
			d_clamped = diff[DW-1:0];
		end else if (diff[DW]) begin
			d_clamped = {1'b1, {(DW-1){1'b0}}};
		end else begin
			d_clamped = {1'b0, {(DW-1){1'b1}}};
		end
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			csplev_pkg::ST_IDLE: begin
				if (eval_acc) begin
					state_nxt = csplev_pkg::ST_RD_UP;
				end
			end
			csplev_pkg::ST_RD_UP:  state_nxt = csplev_pkg::ST_CMP_UP;
			csplev_pkg::ST_CMP_UP: begin
				state_nxt = found ? csplev_pkg::ST_RD_LO : csplev_pkg::ST_RD_UP;
			end
			csplev_pkg::ST_RD_LO:  state_nxt = csplev_pkg::ST_DELTA;
			csplev_pkg::ST_DELTA:  state_nxt = csplev_pkg::ST_MUL;
			csplev_pkg::ST_MUL:    state_nxt = csplev_pkg::ST_ADD;
			csplev_pkg::ST_ADD: begin
				state_nxt = (k_q == 2'd3) ? csplev_pkg::ST_DONE : csplev_pkg::ST_MUL;
			end
			csplev_pkg::ST_DONE: begin
				if (out_free) begin
					state_nxt = csplev_pkg::ST_IDLE;
				end
			end
			default: state_nxt = csplev_pkg::ST_IDLE;
		endcase
	end

	// memory reads and multiplier enable per state
	always_comb begin
		brk_re    = 1'b0;
		brk_raddr = BAW'(i_q) + BAW'(1);
		cf_re     = 1'b0;
		cf_raddr  = {i_q, k_q};
		mul_en    = 1'b0;
		unique case (state_q)
			csplev_pkg::ST_RD_UP: begin
				brk_re = 1'b1;
			end
			csplev_pkg::ST_RD_LO: begin
				brk_re    = 1'b1;
				brk_raddr = BAW'(i_q);
				cf_re     = 1'b1;
				cf_raddr  = {i_q, 2'd0};
			end
			csplev_pkg::ST_DELTA: begin
				cf_re    = 1'b1;
				cf_raddr = {i_q, 2'd1};
			end
			csplev_pkg::ST_MUL: begin
				mul_en = 1'b1;
			end
			csplev_pkg::ST_ADD: begin
				cf_re    = (k_q != 2'd3);
				cf_raddr = {i_q, k_q + 2'd1};
			end
			default: begin
			end
		endcase
	end

	// sequencer and configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= csplev_pkg::ST_IDLE;
			seg_count_q <= CW'(1);
		end else begin
			state_q <= state_nxt;
			if (cfg_valid && cfg_ready) begin
				seg_count_q <= cfg_data;
			end
		end
	end

	// evaluation datapath
	always_ff @(posedge clk) begin
		case (state_q)
			csplev_pkg::ST_IDLE: begin
				x_q      <= value;
				n_last_q <= SGW'(n_eff - CW'(1));
				i_q      <= '0;
				sat_q    <= 1'b0;
			end
			csplev_pkg::ST_CMP_UP: begin
				if (!found) begin
					i_q <= i_q + SGW'(1);
				end
			end
			csplev_pkg::ST_DELTA: begin
				d_q   <= d_clamped;
				sat_q <= d_ovf;
				acc_q <= cf_rdata;
				k_q   <= 2'd1;
			end
			csplev_pkg::ST_ADD: begin
				acc_q <= mac_sum;
				sat_q <= sat_q || mac_ovf;
				k_q   <= k_q + 2'd1;
			end
			default: begin
			end
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == csplev_pkg::ST_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == csplev_pkg::ST_DONE && out_free) begin
			result_q    <= acc_q;
			segment_q   <= i_q;
			saturated_q <= sat_q;
		end
	end

	// break table
	csplev_ram #(
		.WIDTH(DW),
		.DEPTH(csplev_pkg::NBREAK)
	) u_brk_ram (
		.clk   (clk),
		.we    (brk_we),
		.waddr (index[BAW-1:0]),
		.wdata (value),
		.re    (brk_re),
		.raddr (brk_raddr),
		.rdata (brk_rdata)
	);

	// coefficient table
	csplev_ram #(
		.WIDTH(DW),
		.DEPTH(csplev_pkg::NCOEFF)
	) u_cf_ram (
		.clk   (clk),
		.we    (cf_we),
		.waddr (index[CAW-1:0]),
		.wdata (value),
		.re    (cf_re),
		.raddr (cf_raddr),
		.rdata (cf_rdata)
	);

	// Horner step
	csplev_mac u_mac (
		.clk    (clk),
		.mul_en (mul_en),
		.mul_a  (acc_q),
		.mul_b  (d_q),
		.addend (cf_rdata),
		.sum    (mac_sum),
		.ovf    (mac_ovf)
	);

endmodule

`default_nettype wire

// ===== rtl/csplev_checker.sv =====
// Port-level checks for the spline evaluator, bound to the top level.
// Depends on csplev_pkg for the action codes and widths.
`default_nettype none

module csplev_checker (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          in_valid,
	input wire logic                          in_stall,
	input wire logic [1:0]                    action,
	input wire logic                          out_valid,
	input wire logic                          out_stall,
	input wire logic [csplev_pkg::DATA_W-1:0] result,
	input wire logic [csplev_pkg::SEG_W-1:0]  segment,
	input wire logic                          saturated
);

	// a stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(result)
			&& $stable(segment) && $stable(saturated))
		else $error("result word changed while stalled");

	// an accepted evaluate word keeps the input stalled in the next cycle
	a_eval_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && action == csplev_pkg::ACT_EVAL |=> in_stall)
		else $error("input not stalled after an evaluate word");

	// a write word never stalls the input afterwards
	a_write_free: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && action != csplev_pkg::ACT_EVAL |=> !in_stall)
		else $error("input stalled after a write word");

	// a result only appears at the end of a running evaluation
	a_out_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result appeared without an evaluation in progress");

endmodule

bind cubic_spline_evaluator_core csplev_checker u_checker (.*);

`default_nettype wire

// ===== dv/testbench.sv =====
// Testbench for cubic_spline_evaluator_core: loads the break and coefficient tables,
// runs evaluations under random gaps and stalls, and checks each result word against
// a built-in Q16.16 spline model. Depends on csplev_pkg and the core RTL.
`default_nettype none

module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [1:0] ACT_NONE = 2'd3;    // unused action code, dropped by the block
	localparam int SETTLE      = 60;
	localparam int HOLD_CYCLES = 400;
	localparam int IDLE_LIMIT  = 3000;
	localparam int RAND_PHASES = 8;
	localparam int PHASE_WORDS = 62;
	localparam int HOLD_PHASE  = 3;
	localparam longint WORD_MAX = 64'sd2147483647;
	localparam longint WORD_MIN = -64'sd2147483648;

	typedef struct packed {
		logic [1:0]                    act;
		logic [5:0]                    idx;
		logic [csplev_pkg::DATA_W-1:0] val;
	} spline_word_t;

	typedef struct packed {
		logic [csplev_pkg::DATA_W-1:0] val;
		logic [csplev_pkg::SEG_W-1:0]  seg;
		logic                          sat;
	} spline_res_t;

	// clock and reset
	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	// block ports
	logic                          in_valid  = 1'b0;
	logic                          in_stall;
	logic [1:0]                    action    = '0;
	logic [5:0]                    index     = '0;
	logic [csplev_pkg::DATA_W-1:0] value     = '0;
	logic                          out_valid;
	logic                          out_stall = 1'b0;
	logic [csplev_pkg::DATA_W-1:0] result;
	logic [csplev_pkg::SEG_W-1:0]  segment;
	logic                          saturated;
	logic                          cfg_valid = 1'b0;
	logic                          cfg_ready;
	logic [csplev_pkg::CNT_W-1:0]  cfg_data  = '0;

	// model state
	logic signed [csplev_pkg::DATA_W-1:0] brk_tab [csplev_pkg::NBREAK];
	logic signed [csplev_pkg::DATA_W-1:0] coef_tab [csplev_pkg::NCOEFF];
	logic [csplev_pkg::CNT_W-1:0]         seg_count = csplev_pkg::CNT_W'(1);

	spline_word_t pending_words [$];
	spline_res_t  spline_vals_q [$];

	// pacing
	int   send_gap    = 0;
	int   rx_wait     = 0;
	int   hold_left   = 0;
	int   hold_req    = 0;
	int   hold_seen   = 0;
	int   mode_left   = 0;
	logic tx_idle     = 1'b1;
	logic rx_idle     = 1'b1;
	int   mismatches  = 0;
	int   quiet_cycles = 0;

	cubic_spline_evaluator_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.action    (action),
		.index     (index),
		.value     (value),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.result    (result),
		.segment   (segment),
		.saturated (saturated),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// clip to the signed 32-bit range, noting any clip
	function automatic longint clip_word(input longint v, inout logic sat);
		if (v > WORD_MAX) begin
			sat = 1'b1;
			return WORD_MAX;
		end
		if (v < WORD_MIN) begin
			sat = 1'b1;
			return WORD_MIN;
		end
		return v;
	endfunction

	// expected output word for an evaluation at x
	function automatic spline_res_t eval_spline(
			input logic signed [csplev_pkg::DATA_W-1:0] x);
		int          n;
		int          i;
		int          k;
		longint      d;
		longint      acc;
		logic        sat;
		spline_res_t r;
		n = (seg_count == 0) ? 1 : ((seg_count > csplev_pkg::MAX_SEGMENTS)
			? csplev_pkg::MAX_SEGMENTS : seg_count);
		sat = 1'b0;
		// first interval whose upper break is at least x, else the last one
		for (i = 0; i < n; i++) begin
			if (longint'(x) <= longint'(brk_tab[i + 1]))
				break;
		end
		if (i == n)
			i = n - 1;
		d = clip_word(longint'(x) - longint'(brk_tab[i]), sat);
		// Horner steps, product rounded half up before the add
		acc = longint'(coef_tab[4 * i]);
		for (k = 1; k <= 3; k++) begin
			acc = ((acc * d) + (longint'(1) << (csplev_pkg::FRAC_BITS - 1)))
				>>> csplev_pkg::FRAC_BITS;
			acc = clip_word(acc + longint'(coef_tab[4 * i + k]), sat);
		end
		r.val = acc[csplev_pkg::DATA_W-1:0];
		r.seg = i[csplev_pkg::SEG_W-1:0];
		r.sat = sat;
		return r;
	endfunction

	// effect of one accepted input word on tables and expected results
	function automatic void apply_word(input spline_word_t w);
		case (w.act)
			csplev_pkg::ACT_WR_BREAK: begin
				if (w.idx < csplev_pkg::NBREAK)
					brk_tab[w.idx] = w.val;
			end
			csplev_pkg::ACT_WR_COEFF: begin
				if (w.idx < csplev_pkg::NCOEFF)
					coef_tab[w.idx] = w.val;
			end
			csplev_pkg::ACT_EVAL: begin
				spline_vals_q.push_back(eval_spline(w.val));
			end
			default: ;
		endcase
	endfunction

	function automatic logic signed [csplev_pkg::DATA_W-1:0] nominal_break(input int k);
		return (2 * k - 16) * 65536;
	endfunction

	task automatic note_mismatch(input string msg);
		mismatches++;
		if (mismatches <= 10)
			$display("%0t: mismatch: %s", $realtime, msg);
	endtask

	task automatic push_word(input logic [1:0] act, input logic [5:0] idx,
			input logic [csplev_pkg::DATA_W-1:0] val);
		spline_word_t w;
		w.act = act;
		w.idx = idx;
		w.val = val;
		pending_words.push_back(w);
	endtask

	task automatic write_count(input logic [csplev_pkg::CNT_W-1:0] v);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		seg_count = v;
	endtask

	// sender stops until every expected result word is back, then lets the block settle;
	// sampled at the falling edge so the driver's updates of the same edge are in place
	task automatic wait_drained();
		while (pending_words.size() != 0 || in_valid || spline_vals_q.size() != 0)
			@(negedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// idle modes change at random intervals, some stretches run without gaps
	always @(posedge clk) begin
		if (mode_left == 0) begin
			tx_idle   <= ($urandom_range(0, 3) != 0);
			rx_idle   <= ($urandom_range(0, 3) != 0);
			mode_left <= $urandom_range(100, 400);
		end else begin
			mode_left <= mode_left - 1;
		end
	end

	// input driver: one word per handshake, random gap before each
	always @(posedge clk) begin : drive_in
		spline_word_t w;
		logic         nv;
		if (!arst_n) begin
			in_valid <= 1'b0;
			send_gap <= 0;
		end else begin
			nv = in_valid;
			if (in_valid && !in_stall) begin
				w.act = action;
				w.idx = index;
				w.val = value;
				apply_word(w);
				nv = 1'b0;
			end
			if (!nv) begin
				if (send_gap > 0) begin
					send_gap <= send_gap - 1;
				end else if (pending_words.size() != 0) begin
					w = pending_words.pop_front();
					action   <= w.act;
					index    <= w.idx;
					value    <= w.val;
					nv       = 1'b1;
					send_gap <= tx_idle ? $urandom_range(0, 6) : 0;
				end
			end
			in_valid <= nv;
		end
	end

	// output stall: random wait per word, plus a long hold on request
	always @(posedge clk) begin : pace_out
		int w;
		int h;
		if (!arst_n) begin
			out_stall <= 1'b0;
			rx_wait   <= 0;
			hold_left <= 0;
		end else begin
			w = rx_wait;
			h = hold_left;
			if (out_valid && !out_stall)
				w = rx_idle ? $urandom_range(0, 6) : 0;
			else if (out_valid && w > 0)
				w = w - 1;
			if (hold_seen != hold_req)
				h = HOLD_CYCLES;
			else if (h > 0)
				h = h - 1;
			hold_seen <= hold_req;
			rx_wait   <= w;
			hold_left <= h;
			out_stall <= (w > 0) || (h > 0);
		end
	end

	// output monitor
	always @(posedge clk) begin : check_out
		spline_res_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (spline_vals_q.size() == 0) begin
				note_mismatch($sformatf("unexpected word result %h segment %0d saturated %b",
					result, segment, saturated));
			end else begin
				e = spline_vals_q.pop_front();
				if (result !== e.val || segment !== e.seg || saturated !== e.sat)
					note_mismatch($sformatf(
						"result %h segment %0d saturated %b, expected %h %0d %b",
						result, segment, saturated, e.val, e.seg, e.sat));
			end
		end
	end

	// watchdog on handshake activity
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles + 1 >= IDLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		int                                   p;
		int                                   k;
		int                                   r;
		logic signed [csplev_pkg::DATA_W-1:0] v;
		logic [5:0]                           idx;
		logic [csplev_pkg::CNT_W-1:0]         cnt;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// fill both tables so no evaluation ever reads an unwritten entry
		for (k = 0; k < csplev_pkg::NBREAK; k++)
			push_word(csplev_pkg::ACT_WR_BREAK, 6'(k), nominal_break(k));
		for (k = 0; k < csplev_pkg::NCOEFF; k++)
			push_word(csplev_pkg::ACT_WR_COEFF, 6'(k), $signed($urandom) >>> 14);

		// one interval (reset count): extremes, break edges, ignored words, clipping
		push_word(csplev_pkg::ACT_EVAL, 6'd0, 32'h8000_0000);
		push_word(csplev_pkg::ACT_EVAL, 6'd63, 32'h7fff_ffff);
		push_word(csplev_pkg::ACT_EVAL, 6'd0, nominal_break(0));
		push_word(csplev_pkg::ACT_EVAL, 6'd0, nominal_break(1));
		push_word(csplev_pkg::ACT_EVAL, 6'd0, nominal_break(1) + 1);
		push_word(csplev_pkg::ACT_EVAL, 6'd0, 32'h0000_8000);
		push_word(csplev_pkg::ACT_WR_BREAK, 6'd17, 32'h0000_0000);
		push_word(csplev_pkg::ACT_WR_BREAK, 6'd63, 32'hffff_ffff);
		push_word(ACT_NONE, 6'h2a, 32'h1234_5678);
		push_word(csplev_pkg::ACT_WR_COEFF, 6'd2, 32'h7fff_ffff);
		push_word(csplev_pkg::ACT_WR_COEFF, 6'd3, 32'h7fff_ffff);
		push_word(csplev_pkg::ACT_EVAL, 6'd0, nominal_break(0) + 32'sh0002_0000);
		push_word(csplev_pkg::ACT_WR_COEFF, 6'd2, 32'h8000_0000);
		push_word(csplev_pkg::ACT_EVAL, 6'd0, nominal_break(0) + 32'sh0002_0000);
		push_word(csplev_pkg::ACT_WR_COEFF, 6'd2, 32'h0000_4000);
		push_word(csplev_pkg::ACT_WR_COEFF, 6'd3, 32'hffff_c000);
		push_word(csplev_pkg::ACT_WR_COEFF, 6'd63, 32'h8000_0000);
		wait_drained();

		// all sixteen intervals
		write_count(csplev_pkg::CNT_W'(csplev_pkg::MAX_SEGMENTS));
		push_word(csplev_pkg::ACT_EVAL, 6'd0, 32'h8000_0000);
		push_word(csplev_pkg::ACT_EVAL, 6'd0, 32'h7fff_ffff);
		push_word(csplev_pkg::ACT_EVAL, 6'd0, nominal_break(16));
		push_word(csplev_pkg::ACT_EVAL, 6'd0, nominal_break(8));
		push_word(csplev_pkg::ACT_EVAL, 6'd0, nominal_break(8) + 1);
		wait_drained();

		// counts out of range: zero acts as one, above the maximum as the maximum
		write_count(csplev_pkg::CNT_W'(0));
		push_word(csplev_pkg::ACT_EVAL, 6'd0, 32'h7fff_ffff);
		wait_drained();
		write_count(csplev_pkg::CNT_W'(31));
		push_word(csplev_pkg::ACT_EVAL, 6'd0, 32'h7fff_ffff);
		wait_drained();

		// random phases
		for (p = 0; p < RAND_PHASES; p++) begin
			case (p)
				0: cnt = csplev_pkg::CNT_W'(csplev_pkg::MAX_SEGMENTS);
				1: cnt = csplev_pkg::CNT_W'(1);
				default: begin
					r = $urandom_range(0, 9);
					if (r == 0)
						cnt = csplev_pkg::CNT_W'($urandom_range(17, 31));
					else if (r == 1)
						cnt = csplev_pkg::CNT_W'(0);
					else
						cnt = csplev_pkg::CNT_W'($urandom_range(2, 15));
				end
			endcase
			write_count(cnt);
			for (k = 0; k < PHASE_WORDS; k++) begin
				r = $urandom_range(0, 99);
				if (r < 60) begin
					// evaluate, mostly near a break so every interval gets hit
					if ($urandom_range(0, 9) == 0)
						v = $urandom;
					else
						v = nominal_break($urandom_range(0, 16))
							+ ($signed($urandom) >>> $urandom_range(13, 20));
					push_word(csplev_pkg::ACT_EVAL, 6'($urandom), v);
				end else if (r < 78) begin
					if ($urandom_range(0, 7) == 0)
						v = $urandom;
					else
						v = $signed($urandom) >>> $urandom_range(10, 18);
					push_word(csplev_pkg::ACT_WR_COEFF, 6'($urandom_range(0, 63)), v);
				end else if (r < 93) begin
					// breaks stay mostly ordered, jitter below half the spacing
					if ($urandom_range(0, 9) == 0)
						idx = 6'($urandom_range(csplev_pkg::NBREAK, 63));
					else
						idx = 6'($urandom_range(0, csplev_pkg::NBREAK - 1));
					if ($urandom_range(0, 7) == 0)
						v = $urandom;
					else
						v = nominal_break(idx) + ($signed($urandom) >>> 17);
					push_word(csplev_pkg::ACT_WR_BREAK, idx, v);
				end else begin
					push_word(ACT_NONE, 6'($urandom), $urandom);
				end
			end
			// long output hold while the sender keeps offering words
			if (p == HOLD_PHASE)
				hold_req <= hold_req + 1;
			wait_drained();
		end

		if (mismatches == 0 && spline_vals_q.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

`default_nettype wire
